// ===== hw/rtl/clq_pkg.sv =====
package clq_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NUM_PROTOTYPES_DEF = 16;

  localparam int FUNC_W = 2;
  localparam int COORD_W = 24;
  localparam int IDX_OUT_W = 6;
  localparam int W_W = COORD_W + FRACTION_BITS;
  localparam int DIST_W = W_W + 1;
  localparam int SQ_W = 2 * DIST_W;
  localparam int DISP_W = 56;
  localparam int RATE_W = 16;
  localparam int RATE_SHIFT = 16;
  localparam int LO_W = 24;
  localparam int PROD_W = DIST_W + RATE_W + 1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EPOCH  = 2'd2;

  localparam logic REG_INIT_RATE = 1'b0;
  localparam logic REG_DECAY     = 1'b1;

  localparam logic [RATE_W-1:0] INIT_RATE_RST = 16'd6554;
  localparam logic [RATE_W-1:0] DECAY_RST     = 16'd62259;

  localparam logic signed [W_W-1:0] ONE_Q = W_W'(1) << FRACTION_BITS;
  localparam logic signed [W_W-1:0] LAST_RST = -ONE_Q;
  localparam logic signed [W_W-1:0] OLDER_RST = -(ONE_Q <<< 1);

  typedef struct packed {
    logic signed [W_W-1:0] wx;
    logic signed [W_W-1:0] wy;
  } weight_t;

  typedef struct packed {
    logic signed [W_W-1:0] last_x;
    logic signed [W_W-1:0] last_y;
    logic signed [W_W-1:0] older_x;
    logic signed [W_W-1:0] older_y;
    logic [DISP_W-1:0]     disp;
  } hist_t;

  localparam hist_t HIST_RST = '{LAST_RST, LAST_RST, OLDER_RST, OLDER_RST, '0};

  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] best;
  } dist_res_t;

endpackage

// ===== hw/rtl/clq_in_if.sv =====
interface clq_in_if;
  import clq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [IDX_OUT_W-1:0]      proto_index;

  modport source (output valid, func, coord_x, coord_y, proto_index, input ready);
  modport sink (input valid, func, coord_x, coord_y, proto_index, output ready);
endinterface

// ===== hw/rtl/clq_out_if.sv =====
interface clq_out_if;
  import clq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [IDX_OUT_W-1:0]  winner;
  logic [DIST_W-1:0]     distance;
  logic signed [W_W-1:0] weight_x;
  logic signed [W_W-1:0] weight_y;
  logic [DISP_W-1:0]     dispersion;
  logic                  converged;
  logic                  last;

  modport source (output valid, winner, distance, weight_x, weight_y, dispersion,
                  converged, last, input ready);
  modport sink (input valid, winner, distance, weight_x, weight_y, dispersion,
                converged, last, output ready);
endinterface

// ===== hw/rtl/clq_dist.sv =====
module clq_dist #(
  parameter int IDX_W = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_vld,
  input  logic                              in_last,
  input  logic [IDX_W-1:0]                  in_idx,
  input  clq_pkg::weight_t                  w,
  input  logic signed [clq_pkg::W_W-1:0]    xq,
  input  logic signed [clq_pkg::W_W-1:0]    yq,
  output clq_pkg::dist_res_t                res,
  output logic [IDX_W-1:0]                  win
);
  import clq_pkg::*;

  localparam int HI_W = DIST_W - LO_W;

  logic signed [DIST_W-1:0] dx, dy;
  logic [DIST_W-1:0] mag_x_r, mag_y_r;
  logic [2*HI_W-1:0] xhh_r, yhh_r;
  logic [HI_W+LO_W-1:0] xhl_r, yhl_r;
  logic [2*LO_W-1:0] xll_r, yll_r;
  logic [SQ_W-1:0] sq_x_r, sq_y_r, sum_r, best_r;
  logic [4:1] v_r, l_r;
  logic [IDX_W-1:0] i1_r, i2_r, i3_r, i4_r, win_r;
  logic first_r, done_r;

  assign dx = DIST_W'(w.wx) - DIST_W'(xq);
  assign dy = DIST_W'(w.wy) - DIST_W'(yq);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      first_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v_r <= {v_r[3:1], in_vld};
      done_r <= v_r[4] && l_r[4];
      if (start) begin
        first_r <= 1'b1;
      end else if (v_r[4]) begin
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    l_r <= {l_r[3:1], in_last};
    i1_r <= in_idx;
    i2_r <= i1_r;
    i3_r <= i2_r;
    i4_r <= i3_r;
    mag_x_r <= dx[DIST_W-1] ? DIST_W'(-dx) : DIST_W'(dx);
    mag_y_r <= dy[DIST_W-1] ? DIST_W'(-dy) : DIST_W'(dy);
    // square split into partial products of the upper and lower parts
    xhh_r <= mag_x_r[DIST_W-1:LO_W] * mag_x_r[DIST_W-1:LO_W];
    xhl_r <= mag_x_r[DIST_W-1:LO_W] * mag_x_r[LO_W-1:0];
    xll_r <= mag_x_r[LO_W-1:0] * mag_x_r[LO_W-1:0];
    yhh_r <= mag_y_r[DIST_W-1:LO_W] * mag_y_r[DIST_W-1:LO_W];
    yhl_r <= mag_y_r[DIST_W-1:LO_W] * mag_y_r[LO_W-1:0];
    yll_r <= mag_y_r[LO_W-1:0] * mag_y_r[LO_W-1:0];
    sq_x_r <= (SQ_W'(xhh_r) << (2*LO_W)) + (SQ_W'(xhl_r) << (LO_W+1)) + SQ_W'(xll_r);
    sq_y_r <= (SQ_W'(yhh_r) << (2*LO_W)) + (SQ_W'(yhl_r) << (LO_W+1)) + SQ_W'(yll_r);
    sum_r <= sq_x_r + sq_y_r;
    // strict compare keeps the lowest index on a tie
    if (v_r[4] && (first_r || sum_r < best_r)) begin
      best_r <= sum_r;
      win_r <= i4_r;
    end
  end

  assign res.done = done_r;
  assign res.best = best_r;
  assign win = win_r;
endmodule

// ===== hw/rtl/clq_sqrt.sv =====
module clq_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [clq_pkg::SQ_W-1:0]      val,
  output logic                          valid,
  output logic [clq_pkg::DIST_W-1:0]    root
);
  import clq_pkg::*;

  localparam int REM_W = DIST_W + 3;
  localparam int CNT_W = $clog2(DIST_W);

  logic [SQ_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r, rem_sh, trial;
  logic [DIST_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic run_r, valid_r, take;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[SQ_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});
  assign take = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
      valid_r <= 1'b0;
    end else if (run_r && cnt_r == '0) begin
      run_r <= 1'b0;
      valid_r <= 1'b1;
    end
  end

  // one result bit per cycle, two radicand bits brought down each step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= val;
      rem_r <= '0;
      root_r <= '0;
      cnt_r <= CNT_W'(DIST_W - 1);
    end else if (run_r) begin
      rad_r <= rad_r << 2;
      cnt_r <= cnt_r - 1'b1;
      if (take) begin
        rem_r <= rem_sh - trial;
        root_r <= {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        root_r <= {root_r[DIST_W-2:0], 1'b0};
      end
    end
  end

  assign valid = valid_r;
  assign root = root_r;
endmodule

// ===== hw/rtl/competitive_learning_quantizer.sv =====
// Competitive learning quantizer, winner take all.
// in_ch carries one transaction per command: func 1 loads a prototype, func 0
// presents a sample, func 2 closes an epoch. out_ch returns one transaction per
// sample and NUM_PROTOTYPES transactions per epoch end, the final one with last set.
// Rates are set through the cfg_ APB port (initial rate at 0x0, decay at 0x4).
// A load writes the prototype memory directly from idle. During a sample the
// prototype memory is read one entry per cycle into a five stage distance pipeline,
// then the square root unit produces one result bit per cycle while the winner's
// weight update runs alongside. An epoch end makes a convergence pass and then a
// report pass over all prototypes, one memory read per entry and pass.
// The result sits in an output register, so the next command is taken while it
// waits; if the receiver stalls during an epoch report the report pass waits.
// Reset restores the rates and marks all history and dispersion entries as at
// their reset values; prototype weights are undefined until loaded.
module competitive_learning_quantizer #(
  parameter int NUM_PROTOTYPES = clq_pkg::NUM_PROTOTYPES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  clq_in_if.sink                       in_ch,
  clq_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [clq_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [clq_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [clq_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import clq_pkg::*;

  localparam int IDX_W = (NUM_PROTOTYPES > 1) ? $clog2(NUM_PROTOTYPES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PROTOTYPES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_UPD_DIFF, S_UPD_MUL, S_UPD_SUM, S_SQRT_WAIT,
    S_EP1_RD, S_EP1_CHK, S_EP2_RD, S_EP2_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt, win_r;
  logic signed [W_W-1:0] x_r, y_r, xq_in, yq_in;
  logic [RATE_W-1:0] rate_r, init_rate_r, decay_r;
  logic [2*RATE_W-1:0] rate_prod;
  logic conv_r, conv_set;

  // memories
  weight_t wmem [NUM_PROTOTYPES];
  hist_t hmem [NUM_PROTOTYPES];
  logic [NUM_PROTOTYPES-1:0] h_valid_r;
  weight_t a_rdata_r, a_wd;
  hist_t b_rdata_r, b_wd, b_eff;
  logic b_vld_r;
  logic a_re, a_we, b_re, b_we;
  logic [IDX_W-1:0] a_ra, a_wa, b_ra, b_wa;

  logic scan_vld_r, scan_last_r;
  logic [IDX_W-1:0] scan_idx_r;

  logic dist_start, sqrt_start, sqrt_valid;
  dist_res_t dist_res;
  logic [IDX_W-1:0] dist_win;
  logic [DIST_W-1:0] root;

  logic signed [DIST_W-1:0] dx_r, dy_r;
  logic [RATE_W+LO_W-1:0] px_lo_r, py_lo_r;
  logic signed [RATE_W+DIST_W-LO_W:0] px_hi_r, py_hi_r;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  weight_t nw_r;

  logic [DISP_W:0] disp_sum;
  logic [DISP_W-1:0] disp_new;

  logic in_acc, slot_free, out_load, out_valid_r, cfg_wr, load_ok, match;
  logic [IDX_OUT_W-1:0] o_winner_nxt, o_winner_r;
  logic [DIST_W-1:0] o_dist_nxt, o_dist_r;
  weight_t o_w_nxt, o_w_r;
  logic [DISP_W-1:0] o_disp_nxt, o_disp_r;
  logic o_conv_nxt, o_conv_r, o_last_nxt, o_last_r;

  assign xq_in = {in_ch.coord_x, FRACTION_BITS'(0)};
  assign yq_in = {in_ch.coord_y, FRACTION_BITS'(0)};
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign load_ok = {1'b0, in_ch.proto_index} < (IDX_OUT_W + 1)'(NUM_PROTOTYPES);
  assign slot_free = !out_valid_r || out_ch.ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_DECAY) ? CFG_DW'(decay_r) : CFG_DW'(init_rate_r);

  assign b_eff = b_vld_r ? b_rdata_r : HIST_RST;
  assign match = a_rdata_r.wx == b_eff.last_x && a_rdata_r.wx == b_eff.older_x &&
                 a_rdata_r.wy == b_eff.last_y && a_rdata_r.wy == b_eff.older_y;

  assign disp_sum = {1'b0, b_eff.disp} + (DISP_W + 1)'(root);
  assign disp_new = disp_sum[DISP_W] ? '1 : disp_sum[DISP_W-1:0];

  // rate * diff from its partial products; shifted right by the rate's fraction where it is added
  assign prod_x = (PROD_W'(px_hi_r) <<< LO_W) + $signed(PROD_W'(px_lo_r));
  assign prod_y = (PROD_W'(py_hi_r) <<< LO_W) + $signed(PROD_W'(py_lo_r));
  assign rate_prod = rate_r * decay_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    a_re = 1'b0;
    a_ra = cnt_r;
    a_we = 1'b0;
    a_wa = win_r;
    a_wd = nw_r;
    b_re = 1'b0;
    b_ra = cnt_r;
    b_we = 1'b0;
    b_wa = cnt_r;
    b_wd = b_eff;
    dist_start = 1'b0;
    sqrt_start = 1'b0;
    out_load = 1'b0;
    conv_set = 1'b0;
    o_winner_nxt = IDX_OUT_W'(cnt_r);
    o_dist_nxt = '0;
    o_w_nxt = a_rdata_r;
    o_disp_nxt = b_eff.disp;
    o_conv_nxt = conv_r;
    o_last_nxt = (cnt_r == LAST_IDX);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt = '0;
          priority if (in_ch.func == FUNC_LOAD) begin
            a_we = load_ok;
            a_wa = in_ch.proto_index[IDX_W-1:0];
            a_wd = '{xq_in, yq_in};
          end else if (in_ch.func == FUNC_SAMPLE) begin
            dist_start = 1'b1;
            state_nxt = S_SCAN;
          end else if (in_ch.func == FUNC_EPOCH) begin
            state_nxt = S_EP1_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        a_re = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        if (dist_res.done) begin
          a_re = 1'b1;
          a_ra = dist_win;
          b_re = 1'b1;
          b_ra = dist_win;
          sqrt_start = 1'b1;
          state_nxt = S_UPD_DIFF;
        end
      end
      S_UPD_DIFF: state_nxt = S_UPD_MUL;
      S_UPD_MUL: state_nxt = S_UPD_SUM;
      S_UPD_SUM: state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        o_winner_nxt = IDX_OUT_W'(win_r);
        o_dist_nxt = root;
        o_w_nxt = nw_r;
        o_disp_nxt = disp_new;
        o_conv_nxt = 1'b0;
        o_last_nxt = 1'b1;
        if (sqrt_valid && slot_free) begin
          out_load = 1'b1;
          a_we = 1'b1;
          b_we = 1'b1;
          b_wa = win_r;
          b_wd.disp = disp_new;
          state_nxt = S_IDLE;
        end
      end
      S_EP1_RD: begin
        a_re = 1'b1;
        b_re = 1'b1;
        state_nxt = S_EP1_CHK;
      end
      S_EP1_CHK: begin
        if (match) begin
          conv_set = 1'b1;
        end else begin
          b_we = 1'b1;
          b_wd.last_x = a_rdata_r.wx;
          b_wd.last_y = a_rdata_r.wy;
          b_wd.older_x = b_eff.last_x;
          b_wd.older_y = b_eff.last_y;
        end
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = S_EP1_RD;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt = '0;
          state_nxt = S_EP2_RD;
        end
      end
      S_EP2_RD: begin
        a_re = 1'b1;
        b_re = 1'b1;
        state_nxt = S_EP2_EMIT;
      end
      S_EP2_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          b_we = 1'b1;
          b_wd.disp = '0;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_EP2_RD;
          if (cnt_r == LAST_IDX) begin
            cnt_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      conv_r <= 1'b0;
      out_valid_r <= 1'b0;
      h_valid_r <= '0;
      scan_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      init_rate_r <= INIT_RATE_RST;
      rate_r <= INIT_RATE_RST;
      decay_r <= DECAY_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      scan_vld_r <= (state_r == S_SCAN);
      if (b_re) begin
        b_vld_r <= h_valid_r[b_ra];
      end
      if (b_we) begin
        h_valid_r[b_wa] <= 1'b1;
      end
      if (in_acc) begin
        conv_r <= 1'b0;
      end else if (conv_set) begin
        conv_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_EP2_EMIT && state_nxt == S_IDLE && !conv_r) begin
        rate_r <= rate_prod[2*RATE_W-1:RATE_SHIFT];
      end
      if (cfg_wr && cfg_paddr[2] == REG_INIT_RATE) begin
        init_rate_r <= cfg_pwdata[RATE_W-1:0];
        rate_r <= cfg_pwdata[RATE_W-1:0];
      end else if (cfg_wr && cfg_paddr[2] == REG_DECAY) begin
        decay_r <= cfg_pwdata[RATE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      wmem[a_wa] <= a_wd;
    end
    if (a_re) begin
      a_rdata_r <= wmem[a_ra];
    end
    if (b_we) begin
      hmem[b_wa] <= b_wd;
    end
    if (b_re) begin
      b_rdata_r <= hmem[b_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= xq_in;
      y_r <= yq_in;
    end
    scan_idx_r <= cnt_r;
    scan_last_r <= (cnt_r == LAST_IDX);
    if (sqrt_start) begin
      win_r <= dist_win;
    end
    dx_r <= DIST_W'(x_r) - DIST_W'(a_rdata_r.wx);
    dy_r <= DIST_W'(y_r) - DIST_W'(a_rdata_r.wy);
    px_lo_r <= rate_r * dx_r[LO_W-1:0];
    py_lo_r <= rate_r * dy_r[LO_W-1:0];
    px_hi_r <= $signed({1'b0, rate_r}) * $signed(dx_r[DIST_W-1:LO_W]);
    py_hi_r <= $signed({1'b0, rate_r}) * $signed(dy_r[DIST_W-1:LO_W]);
    nw_r.wx <= a_rdata_r.wx + prod_x[RATE_SHIFT +: W_W];
    nw_r.wy <= a_rdata_r.wy + prod_y[RATE_SHIFT +: W_W];
    if (out_load) begin
      o_winner_r <= o_winner_nxt;
      o_dist_r <= o_dist_nxt;
      o_w_r <= o_w_nxt;
      o_disp_r <= o_disp_nxt;
      o_conv_r <= o_conv_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  clq_dist #(.IDX_W(IDX_W)) u_dist (
    .clk(clk),
    .rst_n(rst_n),
    .start(dist_start),
    .in_vld(scan_vld_r),
    .in_last(scan_last_r),
    .in_idx(scan_idx_r),
    .w(a_rdata_r),
    .xq(x_r),
    .yq(y_r),
    .res(dist_res),
    .win(dist_win)
  );

  clq_sqrt u_sqrt (
    .clk(clk),
    .rst_n(rst_n),
    .start(sqrt_start),
    .val(dist_res.best),
    .valid(sqrt_valid),
    .root(root)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.winner = o_winner_r;
  assign out_ch.distance = o_dist_r;
  assign out_ch.weight_x = o_w_r.wx;
  assign out_ch.weight_y = o_w_r.wy;
  assign out_ch.dispersion = o_disp_r;
  assign out_ch.converged = o_conv_r;
  assign out_ch.last = o_last_r;
endmodule

// ===== hw/rtl/clq_checker.sv =====
module clq_checker #(
  parameter int NUM_PROTOTYPES = clq_pkg::NUM_PROTOTYPES_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [clq_pkg::IDX_OUT_W-1:0]    out_winner,
  input logic [clq_pkg::DIST_W-1:0]       out_distance,
  input logic                             out_converged,
  input logic                             out_last
);
  import clq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a transaction with nonzero distance is a sample: single and never reports convergence
  a_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance != '0 |-> out_last && !out_converged)
    else $error("sample result malformed");

  a_winner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_winner} < (IDX_OUT_W + 1)'(NUM_PROTOTYPES))
    else $error("winner index out of range");
endmodule

bind competitive_learning_quantizer clq_checker #(.NUM_PROTOTYPES(NUM_PROTOTYPES)) u_clq_chk (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_winner(out_ch.winner),
  .out_distance(out_ch.distance),
  .out_converged(out_ch.converged),
  .out_last(out_ch.last)
);

// ===== verif/tb_competitive_learning_quantizer.sv =====
`timescale 1ns / 100ps

module tb_competitive_learning_quantizer;
  import clq_pkg::*;

  localparam int NPROTO = NUM_PROTOTYPES_DEF;
  localparam int DRAIN_CYCLES = 120;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [DISP_W-1:0] DISP_SAT = '1;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int NUM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 80;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [IDX_OUT_W-1:0]      idx;
  } cmd_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  winner;
    logic [DIST_W-1:0]     distance;
    logic signed [W_W-1:0] wx;
    logic signed [W_W-1:0] wy;
    logic [DISP_W-1:0]     disp;
    logic                  conv;
    logic                  last;
  } result_t;

  typedef struct {
    cmd_t                 cmd;
    bit                   typed;
    logic [IDX_OUT_W-1:0] exp_winner;
    logic [DIST_W-1:0]    exp_dist;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  clq_in_if  in_ch ();
  clq_out_if out_ch ();

  competitive_learning_quantizer DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // quantizer state mirror
  longint      proto_w[NPROTO][2];
  longint      last_w[NPROTO][2];
  longint      older_w[NPROTO][2];
  logic [DISP_W-1:0] disp_sum[NPROTO];
  int unsigned cur_rate, start_rate, decay_rate;

  result_t expected_results[$];
  int  fail_cnt = 0;
  bit  no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void note_fail(string what, result_t e, result_t a);
    fail_cnt++;
    if (fail_cnt <= 10) begin
      $display("mismatch (%s) exp: win=%0d dist=%0d wx=%0d wy=%0d disp=%0d conv=%0d last=%0d",
               what, e.winner, e.distance, e.wx, e.wy, e.disp, e.conv, e.last);
      $display("            got: win=%0d dist=%0d wx=%0d wy=%0d disp=%0d conv=%0d last=%0d",
               a.winner, a.distance, a.wx, a.wy, a.disp, a.conv, a.last);
    end
  endfunction

  function automatic logic [DIST_W-1:0] floor_root(logic [83:0] v);
    logic [41:0] r;
    logic [41:0] c;
    r = '0;
    for (int b = 41; b >= 0; b--) begin
      c = r | (42'd1 << b);
      if (84'(c) * 84'(c) <= v) r = c;
    end
    return r[DIST_W-1:0];
  endfunction

  function automatic longint rate_step(int unsigned rate, longint diff);
    return (longint'(rate) * diff) >>> RATE_SHIFT;
  endfunction

  // returns winner and distance of a sample, pushes all expected transactions
  function automatic void quantize(cmd_t c, output int win, output logic [DIST_W-1:0] dist_v);
    longint xq, yq, dx, dy;
    logic [63:0] ax, ay;
    logic [83:0] s, best;
    logic [DISP_W:0] acc;
    bit conv;
    result_t r;
    xq = longint'(c.x) * 65536;
    yq = longint'(c.y) * 65536;
    win = 0;
    dist_v = '0;
    best = '0;
    case (c.func)
      FUNC_LOAD: begin
        if (c.idx < NPROTO) begin
          proto_w[c.idx][0] = xq;
          proto_w[c.idx][1] = yq;
        end
      end
      FUNC_SAMPLE: begin
        for (int i = 0; i < NPROTO; i++) begin
          dx = proto_w[i][0] - xq;
          dy = proto_w[i][1] - yq;
          ax = dx < 0 ? -dx : dx;
          ay = dy < 0 ? -dy : dy;
          s = 84'(ax) * 84'(ax) + 84'(ay) * 84'(ay);
          if (i == 0 || s < best) begin
            best = s;
            win = i;
          end
        end
        dist_v = floor_root(best);
        acc = disp_sum[win] + dist_v;
        disp_sum[win] = acc > DISP_SAT ? DISP_SAT : acc[DISP_W-1:0];
        proto_w[win][0] += rate_step(cur_rate, xq - proto_w[win][0]);
        proto_w[win][1] += rate_step(cur_rate, yq - proto_w[win][1]);
        r = '{IDX_OUT_W'(win), dist_v, proto_w[win][0][W_W-1:0], proto_w[win][1][W_W-1:0],
              disp_sum[win], 1'b0, 1'b1};
        expected_results.push_back(r);
      end
      FUNC_EPOCH: begin
        conv = 0;
        for (int i = 0; i < NPROTO; i++) begin
          if (proto_w[i][0] == last_w[i][0] && proto_w[i][0] == older_w[i][0] &&
              proto_w[i][1] == last_w[i][1] && proto_w[i][1] == older_w[i][1]) begin
            conv = 1;
          end else begin
            older_w[i] = last_w[i];
            last_w[i] = proto_w[i];
          end
        end
        for (int i = 0; i < NPROTO; i++) begin
          r = '{IDX_OUT_W'(i), '0, proto_w[i][0][W_W-1:0], proto_w[i][1][W_W-1:0],
                disp_sum[i], conv, i == NPROTO - 1};
          expected_results.push_back(r);
          disp_sum[i] = '0;
        end
        if (!conv) cur_rate = (cur_rate * decay_rate) >> 16;
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(cmd_t c, output int win, output logic [DIST_W-1:0] dist_v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= c.func;
    in_ch.coord_x <= c.x;
    in_ch.coord_y <= c.y;
    in_ch.proto_index <= c.idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    quantize(c, win, dist_v);
  endtask

  task automatic write_reg(logic reg_sel, int unsigned value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(reg_sel) << 2;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_sel == REG_INIT_RATE) begin
      start_rate = value & 16'hFFFF;
      cur_rate = start_rate;
    end else begin
      decay_rate = value & 16'hFFFF;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] near_coord(longint w);
    longint v;
    v = (w >>> FRACTION_BITS) + longint'($urandom_range(0, 4000)) - 2000;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    if ($urandom_range(0, 2) == 0) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, 100000)) - 50000);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int r, k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, NPROTO - 1);
    c.idx = IDX_OUT_W'($urandom);
    c.x = rand_coord();
    c.y = rand_coord();
    if (r < 70) begin
      c.func = FUNC_SAMPLE;
      if ($urandom_range(0, 4) != 0) begin
        c.x = near_coord(proto_w[k][0]);
        c.y = near_coord(proto_w[k][1]);
      end
    end else if (r < 82) begin
      c.func = FUNC_LOAD;
      if ($urandom_range(0, 9) != 0) c.idx = IDX_OUT_W'(k);
    end else if (r < 93) begin
      c.func = FUNC_EPOCH;
    end else begin
      c.func = FUNC_UNUSED;
    end
    return c;
  endfunction

  // output side: check and random backpressure
  initial begin
    int hold;
    result_t got, exp_r;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.winner, out_ch.distance, out_ch.weight_x, out_ch.weight_y,
                out_ch.dispersion, out_ch.converged, out_ch.last};
        if (expected_results.size() == 0) begin
          note_fail("unexpected transaction", '0, got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got.winner !== exp_r.winner || got.distance !== exp_r.distance ||
              got.wx !== exp_r.wx || got.wy !== exp_r.wy || got.disp !== exp_r.disp ||
              got.conv !== exp_r.conv || got.last !== exp_r.last)
            note_fail("field", exp_r, got);
        end
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("** competitive_learning_quantizer: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    cmd_t c;
    int win;
    logic [DIST_W-1:0] dist_v;
    int unsigned rate_set[NUM_PHASES];
    int unsigned decay_set[NUM_PHASES];

    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_SAMPLE;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.proto_index = '0;
    for (int i = 0; i < NPROTO; i++) begin
      proto_w[i] = '{0, 0};
      last_w[i] = '{-65536, -65536};
      older_w[i] = '{-131072, -131072};
      disp_sum[i] = '0;
    end
    start_rate = INIT_RATE_RST;
    decay_rate = DECAY_RST;
    cur_rate = start_rate;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // grid prototypes first so no sample ever reads an unloaded entry
    for (int i = 6; i < NPROTO; i++) begin
      c = '{FUNC_LOAD, COORD_W'(i * 1000), COORD_W'(-i * 1000), IDX_OUT_W'(i)};
      send_cmd(c, win, dist_v);
    end
    rows = '{
      '{'{FUNC_LOAD, 24'sd0, 24'sd0, 6'd0}, 0, 0, 0},
      '{'{FUNC_LOAD, 24'sd0, 24'sd0, 6'd1}, 0, 0, 0},
      '{'{FUNC_LOAD, -24'sd8388608, -24'sd8388608, 6'd2}, 0, 0, 0},
      '{'{FUNC_LOAD, 24'sd8388607, 24'sd8388607, 6'd3}, 0, 0, 0},
      '{'{FUNC_LOAD, -24'sd8388608, 24'sd8388607, 6'd4}, 0, 0, 0},
      '{'{FUNC_LOAD, 24'sd8388607, -24'sd8388608, 6'd5}, 0, 0, 0},
      '{'{FUNC_LOAD, 24'sd7, 24'sd7, 6'd63}, 0, 0, 0},
      '{'{FUNC_LOAD, 24'sd9, 24'sd9, 6'd16}, 0, 0, 0},
      '{'{FUNC_UNUSED, -24'sd1, -24'sd1, 6'd63}, 0, 0, 0},
      '{'{FUNC_SAMPLE, 24'sd0, 24'sd0, 6'd0}, 1, 6'd0, '0},
      '{'{FUNC_SAMPLE, 24'sd8388607, 24'sd8388607, 6'd0}, 1, 6'd3, '0},
      '{'{FUNC_SAMPLE, -24'sd8388608, -24'sd8388608, 6'd0}, 1, 6'd2, '0},
      '{'{FUNC_SAMPLE, 24'sd8388607, -24'sd8388608, 6'd0}, 1, 6'd5, '0},
      '{'{FUNC_EPOCH, 24'sd0, 24'sd0, 6'd0}, 0, 0, 0},
      '{'{FUNC_SAMPLE, -24'sd1, 24'sd1, 6'd0}, 0, 0, 0},
      '{'{FUNC_SAMPLE, 24'sd1234567, -24'sd7654321, 6'd0}, 0, 0, 0},
      '{'{FUNC_EPOCH, 24'sd0, 24'sd0, 6'd0}, 0, 0, 0},
      '{'{FUNC_EPOCH, 24'sd0, 24'sd0, 6'd0}, 0, 0, 0},
      '{'{FUNC_EPOCH, 24'sd0, 24'sd0, 6'd0}, 0, 0, 0}
    };
    foreach (rows[i]) begin
      send_cmd(rows[i].cmd, win, dist_v);
      if (rows[i].typed && (win != rows[i].exp_winner || dist_v !== rows[i].exp_dist)) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("mismatch (directed row %0d) exp: win=%0d dist=%0d got: win=%0d dist=%0d",
                   i, rows[i].exp_winner, rows[i].exp_dist, win, dist_v);
      end
    end
    drain();

    rate_set = '{INIT_RATE_RST, 0, 65535, $urandom_range(0, 65535), 32768};
    decay_set = '{DECAY_RST, 65535, 0, $urandom_range(0, 65535), 65535};
    for (int p = 0; p < NUM_PHASES; p++) begin
      no_idle = (p == 2);
      write_reg(REG_INIT_RATE, rate_set[p]);
      write_reg(REG_DECAY, decay_set[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_cmd(random_cmd(), win, dist_v);
      end
      // close the phase with an epoch so reports cover every setting
      c = '{FUNC_EPOCH, '0, '0, '0};
      send_cmd(c, win, dist_v);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("** competitive_learning_quantizer: PASSED **");
    end else begin
      $display("** competitive_learning_quantizer: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/clq_pkg.sv
hw/rtl/clq_in_if.sv
hw/rtl/clq_out_if.sv
hw/rtl/clq_dist.sv
hw/rtl/clq_sqrt.sv
hw/rtl/competitive_learning_quantizer.sv
hw/rtl/clq_checker.sv
verif/tb_competitive_learning_quantizer.sv
